### src/sample_history_ring_sequenced_read_macros.svh
// Assertion macros used by the back end of the history ring.
`ifndef SAMPLE_HISTORY_RING_SEQUENCED_READ_MACROS_SVH
`define SAMPLE_HISTORY_RING_SEQUENCED_READ_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define SHRSR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define SHRSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SHRSR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define SHRSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### src/shrsr_pkg.sv
package shrsr_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int WORD_W        = 32;
  localparam int COUNT_W       = 7;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = 1;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef struct packed {
    logic                kind;
    logic [WORD_W-1:0]   stamp_ms;
    logic [WORD_W-1:0]   volt_bits;
    logic [WORD_W-1:0]   amp_bits;
    logic [WORD_W-1:0]   since_seq;
    logic [COUNT_W-1:0]  max_count;
  } request_t;

  typedef struct packed {
    logic                has_record;
    logic [WORD_W-1:0]   stamp_out;
    logic [WORD_W-1:0]   volt_out;
    logic [WORD_W-1:0]   amp_out;
    logic [WORD_W-1:0]   next_seq;
    logic [COUNT_W-1:0]  returned_count;
    logic                last;
  } result_t;

  typedef struct packed {
    logic [WORD_W-1:0] stamp;
    logic [WORD_W-1:0] volt;
    logic [WORD_W-1:0] amp;
  } record_t;

  typedef struct packed {
    op_t                op;
    record_t            rec;
    logic [WORD_W-1:0]  since;
    logic [COUNT_W-1:0] maxc;
  } cmd_t;

endpackage

### src/shrsr_ram.sv
module shrsr_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/shrsr_front.sv
module shrsr_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  shrsr_pkg::request_t request,
  output shrsr_pkg::cmd_t    cmd,
  output logic               cmd_valid,
  input  logic               pop
);

  shrsr_pkg::cmd_t            entries [shrsr_pkg::QUEUE_DEPTH];
  logic [shrsr_pkg::QPTR_W-1:0] wr_ptr;
  logic [shrsr_pkg::QPTR_W-1:0] rd_ptr;
  logic [shrsr_pkg::QPTR_W:0]   fill;
  logic                         accept;
  shrsr_pkg::cmd_t            cmd_in;

  // Tag each request as a push or a read before it is queued.
  always_comb begin
    cmd_in.op    = request.kind ? shrsr_pkg::OP_READ : shrsr_pkg::OP_PUSH;
    cmd_in.rec   = '{stamp: request.stamp_ms, volt: request.volt_bits,
                     amp: request.amp_bits};
    cmd_in.since = request.since_seq;
    cmd_in.maxc  = request.max_count;
  end

  assign busy      = (fill == (shrsr_pkg::QPTR_W+1)'(shrsr_pkg::QUEUE_DEPTH));
  assign accept    = start && !busy;
  assign cmd_valid = (fill != '0);
  assign cmd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= (wr_ptr == shrsr_pkg::QPTR_W'(shrsr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == shrsr_pkg::QPTR_W'(shrsr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (shrsr_pkg::QPTR_W+1)'(accept) - (shrsr_pkg::QPTR_W+1)'(pop);
    end
  end

endmodule

### src/shrsr_back.sv
`include "sample_history_ring_sequenced_read_macros.svh"

module shrsr_back #(
  parameter int DEPTH = shrsr_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  shrsr_pkg::cmd_t    cmd,
  input  logic               cmd_valid,
  output logic               pop,
  output logic               strobe,
  output shrsr_pkg::result_t result
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = shrsr_pkg::COUNT_W;
  localparam int WW  = shrsr_pkg::WORD_W;
  localparam int RW  = $bits(shrsr_pkg::record_t);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CLAMP  = 5'b00010,
    ST_SIZE   = 5'b00100,
    ST_PLAN   = 5'b01000,
    ST_STREAM = 5'b10000
  } state_t;

  state_t        state;
  logic [WW-1:0] write_count;
  logic [AW-1:0] write_slot;

  // Read bookkeeping.
  logic [WW-1:0] since;
  logic [CW-1:0] maxc;
  logic          empty;
  logic [CW-1:0] backlog;
  logic [AW-1:0] rd_slot;
  logic [CW-1:0] remaining;
  logic [CW-1:0] avail_q;
  logic [WW-1:0] seq_q;

  // Output registers; record data comes from the RAM's read register.
  logic          strobe_q;
  logic          has_q;
  logic          last_q;
  logic [WW-1:0] next_seq_q;
  logic [CW-1:0] count_q;

  logic          ram_wr;
  logic          ram_rd;
  logic [RW-1:0] ram_q;
  shrsr_pkg::record_t rec_q;

  logic [WW-1:0] span;
  logic [WW-1:0] lo;
  logic [WW-1:0] since_cl;
  logic [CW-1:0] avail;
  logic [CW:0]   ws_ext;
  logic [CW:0]   start_tmp;

  assign pop    = (state == ST_IDLE) && cmd_valid;
  assign ram_wr = pop && (cmd.op == shrsr_pkg::OP_PUSH);
  assign ram_rd = (state == ST_STREAM);

  shrsr_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (write_slot),
    .wr_data (cmd.rec),
    .rd_en   (ram_rd),
    .rd_addr (rd_slot),
    .rd_data (ram_q)
  );

  assign rec_q = ram_q;

  always_comb begin
    span     = (write_count > WW'(DEPTH)) ? WW'(DEPTH) : write_count;
    lo       = write_count - span;
    since_cl = (since < lo) ? lo : ((since > write_count) ? write_count : since);
    avail    = empty ? '0 : ((backlog > maxc) ? maxc : backlog);
    ws_ext   = (CW+1)'(write_slot);
    start_tmp = (ws_ext >= {1'b0, backlog}) ? (ws_ext - {1'b0, backlog})
                                           : (ws_ext + (CW+1)'(DEPTH) - {1'b0, backlog});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      write_count <= '0;
      write_slot  <= '0;
      strobe_q    <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pop) begin
            if (cmd.op == shrsr_pkg::OP_PUSH) begin
              write_count <= write_count + 1'b1;
              write_slot  <= ((write_count == '1) || (write_slot == AW'(DEPTH - 1)))
                             ? '0 : write_slot + 1'b1;
            end else begin
              state <= ST_CLAMP;
            end
          end
        end
        ST_CLAMP: begin
          state <= ST_SIZE;
        end
        ST_SIZE: begin
          state <= ST_PLAN;
        end
        ST_PLAN: begin
          if (avail == '0) begin
            strobe_q <= 1'b1;
            state    <= ST_IDLE;
          end else begin
            state <= ST_STREAM;
          end
        end
        ST_STREAM: begin
          strobe_q <= 1'b1;
          if (remaining == CW'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        since <= cmd.since;
        maxc  <= cmd.maxc;
      end
      ST_CLAMP: begin
        // An empty ring or a zero limit keeps the resume point as given.
        empty <= (maxc == '0) || (write_count == '0);
        if (!((maxc == '0) || (write_count == '0))) begin
          since <= since_cl;
        end
      end
      ST_SIZE: begin
        backlog <= CW'(write_count - since);
      end
      ST_PLAN: begin
        rd_slot   <= start_tmp[AW-1:0];
        remaining <= avail;
        avail_q   <= avail;
        seq_q     <= since + WW'(avail);
        has_q      <= 1'b0;
        last_q     <= 1'b1;
        next_seq_q <= since + WW'(avail);
        count_q    <= '0;
      end
      ST_STREAM: begin
        rd_slot    <= (rd_slot == AW'(DEPTH - 1)) ? '0 : rd_slot + 1'b1;
        remaining  <= remaining - 1'b1;
        has_q      <= 1'b1;
        last_q     <= (remaining == CW'(1));
        next_seq_q <= seq_q;
        count_q    <= avail_q;
      end
      default: begin
      end
    endcase
  end

  assign strobe = strobe_q;

  always_comb begin
    result.has_record     = has_q;
    result.stamp_out      = has_q ? rec_q.stamp : '0;
    result.volt_out       = has_q ? rec_q.volt  : '0;
    result.amp_out        = has_q ? rec_q.amp   : '0;
    result.next_seq       = next_seq_q;
    result.returned_count = count_q;
    result.last           = last_q;
  end

  `SHRSR_ASSERT_IMPL(a_empty_is_last, clk, rst, strobe_q && !has_q, last_q, "empty answer without last")
  `SHRSR_ASSERT_IMPL(a_record_has_count, clk, rst, strobe_q && has_q, count_q != '0, "record with zero count")
  `SHRSR_ASSERT_IMPL(a_stream_not_drained, clk, rst, state == ST_STREAM, remaining != '0, "streaming with nothing left")
  `SHRSR_ASSERT_NEXT(a_final_marked, clk, rst, (state == ST_STREAM) && (remaining == CW'(1)), strobe_q && last_q, "final record not marked last")

endmodule

### src/sample_history_ring_sequenced_read.sv
// A push is held in the request queue, then written to the RAM when the executor pops it; it
// gives no result. A read passes through the clamp, size and plan states; the plan state gives
// an empty answer, else the stream state returns the records one per cycle from the RAM port.
// Pushes retire one per cycle while no read holds the executor.
// busy rises when the two-entry request queue is full; results cannot be stalled.
// Reset (rst, synchronous) empties the queue and clears the count; the RAM is not cleared.
module sample_history_ring_sequenced_read #(
  parameter int DEPTH = shrsr_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  shrsr_pkg::request_t request,
  output logic               strobe,
  output shrsr_pkg::result_t result
);

  // The front end accepts a request when not busy, tags it as a push or a read, and holds it in a
  // short queue, so new requests can still be taken, until it fills, while a long read is being streamed.
  shrsr_pkg::cmd_t cmd;
  logic            cmd_valid;
  logic            pop;

  shrsr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .pop       (pop)
  );

  // The back end owns the record RAM and the running sequence count. It retires pushes
  // without a result; for a read it clamps the resume point into the held window, sizes
  // and plans the read, then reads the records oldest first, one per cycle.
  shrsr_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .pop       (pop),
    .strobe    (strobe),
    .result    (result)
  );

endmodule
